// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 8;
  localparam int OCC_W       = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // One stored entry as seen by a neighbor cell.
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } spq_entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } spq_cmd_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts toward the tail on
// insert below it, and toward the head on removal.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  spq_cmd_t   cmd,
  input  spq_entry_t left_ent,
  input  logic       left_keep,
  input  spq_entry_t right_ent,
  output spq_entry_t ent,
  output logic       keep
);

  logic               slot_valid;
  logic [VALUE_W-1:0] slot_value;
  logic [PRIO_W-1:0]  slot_prio;

  // Hold when this entry ranks at or above the new one.
  assign keep = slot_valid && (slot_prio >= cmd.prio);
  assign ent  = {slot_valid, slot_value, slot_prio};

  always_ff @(posedge clk) begin
    if (cmd.ins && !keep) begin
      if (left_keep) begin
        slot_value <= cmd.value;
        slot_prio  <= cmd.prio;
      end else begin
        slot_value <= left_ent.value;
        slot_prio  <= left_ent.prio;
      end
    end else if (cmd.del) begin
      slot_value <= right_ent.value;
      slot_prio  <= right_ent.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (cmd.ins && !keep) begin
      slot_valid <= left_keep | left_ent.valid;
    end else if (cmd.del) begin
      slot_valid <= right_ent.valid;
    end
  end

endmodule

// ===== src/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries opcode, value and
//   priority_req. Opcode insert places the entry behind all entries of equal
//   or higher priority; opcode remove takes the head entry.
//   Every input transfer yields one result on the output channel
//   (out_valid/out_ready): status, out_value, out_priority, occupancy.
//   The result is registered: out_valid rises in the cycle after the input
//   transfer. Throughput is one item per cycle while the receiver keeps up:
//   every cell compares against the broadcast priority and shifts by one
//   slot in the same cycle, so the chain settles each item as it is taken.
//   The result register takes the next item while its current result is
//   being transferred; when the receiver stalls, in_ready drops and the
//   queue holds.
//   Reset empties the queue (all cell valid bits cleared, count zero) and
//   drops out_valid; stored data is left as is.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic signed [VALUE_W-1:0] value,
  input  logic        [PRIO_W-1:0]  priority_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [1:0]         status,
  output logic signed [VALUE_W-1:0] out_value,
  output logic        [PRIO_W-1:0]  out_priority,
  output logic        [OCC_W-1:0]   occupancy
);

  logic                     in_xfer;
  logic                     full;
  logic                     empty;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  spq_cmd_t                 cmd;
  spq_entry_t               cell_ent  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_keep;
  logic [QUEUE_DEPTH-1:0]   cell_valid;
  spq_status_t              status_next;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign cmd.ins   = in_xfer && (opcode == OP_INSERT) && !full;
  assign cmd.del   = in_xfer && (opcode == OP_REMOVE) && !empty;
  assign cmd.value = value;
  assign cmd.prio  = priority_req;

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (opcode == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_entry_t left_ent;
      spq_entry_t right_ent;
      logic       left_keep;

      if (i == 0) begin : g_head
        assign left_ent  = '0;
        assign left_keep = 1'b1;
      end else begin : g_mid
        assign left_ent  = cell_ent[i-1];
        assign left_keep = cell_keep[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_inner
        assign right_ent = cell_ent[i+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .left_ent  (left_ent),
        .left_keep (left_keep),
        .right_ent (right_ent),
        .ent       (cell_ent[i]),
        .keep      (cell_keep[i])
      );

      assign cell_valid[i] = cell_ent[i].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        count <= count_next;
      end
      if (in_xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: capture on every input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status    <= status_next;
      occupancy <= OCC_W'(count_next);
      if (cmd.del) begin
        out_value    <= cell_ent[0].value;
        out_priority <= cell_ent[0].prio;
      end else begin
        out_value    <= '0;
        out_priority <= '0;
      end
    end
  end

  // Valid cells always match the entry count.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(count))
    else $error("cell valid bits disagree with entry count");

  // Head and next cell stay in priority order.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (cell_ent[0].valid && cell_ent[1].valid) |-> (cell_ent[0].prio >= cell_ent[1].prio))
    else $error("head entry ranks below second entry");

  // Count never passes the depth.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QUEUE_DEPTH)
    else $error("entry count beyond queue depth");

  // A refused insert leaves the occupancy at full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && opcode == OP_INSERT && full) |=>
      (status == ST_FULL && occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full insert not reported correctly");

endmodule
